// File: hdl/pngu_pkg.sv
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
`default_nettype none
package pngu_pkg;

    // Width of the column and byte counters; covers rows of up to 65536 bytes.
    localparam int COL_W = 17;
    // Width of a byte address within a row.
    localparam int IDX_W = 16;
    // Entries in the queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Configuration register indices.
    localparam logic [1:0] CFG_ROW_PIXELS      = 2'd0;
    localparam logic [1:0] CFG_IMAGE_ROWS      = 2'd1;
    localparam logic [1:0] CFG_PIXEL_MODE      = 2'd2;
    localparam logic [1:0] CFG_PALETTE_ENTRIES = 2'd3;

    // Pixel modes.
    localparam logic [1:0] MODE_GRAY = 2'd0;
    localparam logic [1:0] MODE_RGB  = 2'd1;
    localparam logic [1:0] MODE_PAL  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_FILTER  = 2'd1;
    localparam logic [1:0] ERR_PALETTE = 2'd2;

    // Filter types.
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_SUB   = 3'd1;
    localparam logic [2:0] FLT_UP    = 3'd2;
    localparam logic [2:0] FLT_AVG   = 3'd3;
    localparam logic [2:0] FLT_PAETH = 3'd4;
    localparam logic [7:0] FLT_MAX   = 8'd4;

    // Kind of a classified transaction.
    typedef enum logic [1:0] {
        K_FILT,
        K_SAMPLE,
        K_PAL
    } t_kind;

    // Classified transaction handed from the front part to the back part.
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data;
        logic [IDX_W-1:0]   col;
        logic               first_row;
        logic               has_left;
        logic               row_end;
        logic               image_end;
        logic [7:0]         pal_idx;
        logic [23:0]        pal_rgb;
    } t_cmd;

    // Configuration register contents.
    typedef struct packed {
        logic [12:0] row_pixels;
        logic [15:0] image_rows;
        logic [1:0]  pixel_mode;
        logic [8:0]  palette_entries;
    } t_cfg;

    // Absolute difference of two 10-bit values.
    function automatic logic [9:0] absdiff(input logic [9:0] p, input logic [9:0] q);
        absdiff = (p > q) ? (p - q) : (q - p);
    endfunction

    // Paeth predictor: picks the neighbour closest to a + b - c.
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        pa = absdiff({2'b00, b}, {2'b00, c});
        pb = absdiff({2'b00, a}, {2'b00, c});
        pc = absdiff({2'b00, a} + {2'b00, b}, {2'b00, c} + {2'b00, c});
        if (pa <= pb && pa <= pc) begin
            paeth = a;
        end else if (pb <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/pngu_front.sv
// Front part: configuration registers, row and column tracking, transaction classification.
`default_nettype none
module pngu_front #(
    parameter int MAX_ROW_BYTES = 12288
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data,
    input  wire logic           i_valid,
    input  wire logic           i_func,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic [7:0]     i_palette_index,
    input  wire logic [23:0]    i_palette_rgb,
    input  wire logic           i_full,
    output logic                o_push,
    output pngu_pkg::t_cmd      o_cmd,
    output pngu_pkg::t_cfg      o_cfg
);
    import pngu_pkg::*;

    t_cfg               r_cfg;
    logic [COL_W-1:0]   r_col_cnt;
    logic [COL_W-1:0]   n_col_cnt;
    logic [15:0]        r_row_cnt;
    logic [15:0]        n_row_cnt;

    logic               bpp3;
    logic [12:0]        pix;
    logic [15:0]        rb_raw;
    logic [COL_W-1:0]   row_bytes;
    logic [COL_W-1:0]   col_raw;
    logic [COL_W-1:0]   col;
    logic               last_col;
    logic [15:0]        rows;
    logic               last_row;
    logic               accept;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_pixels      <= 13'd1;
            r_cfg.image_rows      <= 16'd1;
            r_cfg.pixel_mode      <= MODE_GRAY;
            r_cfg.palette_entries <= 9'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_PIXELS:      r_cfg.row_pixels      <= i_cfg_data[12:0];
                CFG_IMAGE_ROWS:      r_cfg.image_rows      <= i_cfg_data[15:0];
                CFG_PIXEL_MODE:      r_cfg.pixel_mode      <= i_cfg_data[1:0];
                CFG_PALETTE_ENTRIES: r_cfg.palette_entries <= i_cfg_data[8:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // Row geometry: bytes per row saturated at the line buffer size.
    always_comb begin
        bpp3   = (r_cfg.pixel_mode == MODE_RGB);
        pix    = (r_cfg.row_pixels == 13'd0) ? 13'd1 : r_cfg.row_pixels;
        rb_raw = bpp3 ? ({2'b00, pix, 1'b0} + {3'b000, pix}) : {3'b000, pix};
        if ({1'b0, rb_raw} > COL_W'(MAX_ROW_BYTES)) begin
            row_bytes = COL_W'(MAX_ROW_BYTES);
        end else begin
            row_bytes = {1'b0, rb_raw};
        end
        rows     = (r_cfg.image_rows == 16'd0) ? 16'd1 : r_cfg.image_rows;
        col_raw  = r_col_cnt - COL_W'(1);
        col      = (col_raw >= row_bytes) ? (row_bytes - COL_W'(1)) : col_raw;
        last_col = ((col + COL_W'(1)) >= row_bytes);
        last_row = (({1'b0, r_row_cnt} + 17'd1) >= {1'b0, rows});
    end

    assign accept = i_valid && !i_full;
    assign o_push = accept;

    // Classification of the incoming transaction.
    always_comb begin
        o_cmd.data      = i_data_byte;
        o_cmd.col       = col[IDX_W-1:0];
        o_cmd.first_row = (r_row_cnt == 16'd0);
        o_cmd.has_left  = bpp3 ? (col >= COL_W'(3)) : (col >= COL_W'(1));
        o_cmd.row_end   = last_col;
        o_cmd.image_end = last_col && last_row;
        o_cmd.pal_idx   = i_palette_index;
        o_cmd.pal_rgb   = i_palette_rgb;
        if (i_func) begin
            o_cmd.kind = K_PAL;
        end else if (r_col_cnt == '0) begin
            o_cmd.kind = K_FILT;
        end else begin
            o_cmd.kind = K_SAMPLE;
        end
    end

    // Next column and row counts.
    always_comb begin
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        if (accept && !i_func) begin
            if (r_col_cnt == '0) begin
                n_col_cnt = COL_W'(1);
            end else if (last_col) begin
                n_col_cnt = '0;
                n_row_cnt = last_row ? 16'd0 : (r_row_cnt + 16'd1);
            end else begin
                n_col_cnt = col + COL_W'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pngu_fifo.sv
// Short queue of classified transactions between the front and back parts.
`default_nettype none
module pngu_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  pngu_pkg::t_cmd      i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output pngu_pkg::t_cmd      o_head
);
    import pngu_pkg::*;

    t_cmd                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: hdl/pngu_back.sv
// Back part: line buffer, filter reversal, palette lookup and the output register.
`default_nettype none
module pngu_back #(
    parameter int MAX_ROW_BYTES = 12288,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  pngu_pkg::t_cfg      i_cfg,
    input  wire logic           i_empty,
    input  pngu_pkg::t_cmd      i_head,
    output logic                o_pop,
    input  wire logic           i_stall,
    output logic                o_valid,
    output logic [7:0]          o_out_byte0,
    output logic [7:0]          o_out_byte1,
    output logic [7:0]          o_out_byte2,
    output logic [1:0]          o_error_code,
    output logic                o_row_end,
    output logic                o_image_end,
    output logic                o_all_gray
);
    import pngu_pkg::*;

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int LW = IDX_W + 1;

    logic [7:0]     r_line [MAX_ROW_BYTES];
    logic [23:0]    r_pal [PALETTE_DEPTH];

    logic           en;
    // Stage one: transaction with its line buffer byte.
    logic           r1_v;
    t_cmd           r1_cmd;
    logic [7:0]     r_rd;
    logic           r_unw;
    logic [LW-1:0]  r_line_lim;
    logic           r_fwd;
    logic [7:0]     r_fwd_d;
    logic [2:0]     r_filter;
    logic [23:0]    r_left;
    logic [23:0]    r_ul;
    // Stage two: unfiltered byte with its palette colour.
    logic           r2_v;
    t_kind          r2_kind;
    logic [7:0]     r2_x;
    logic           r2_bad;
    logic           r2_pal;
    logic           r2_ferr;
    logic           r2_first_row;
    logic           r2_rend;
    logic           r2_iend;
    logic [23:0]    r_pal_rd;
    logic           r_gray;
    logic           n_gray;
    logic           r_ov;

    logic           bpp3;
    logic [7:0]     a;
    logic [7:0]     b;
    logic [7:0]     c;
    logic [7:0]     pred;
    logic [8:0]     sum_ab;
    logic [7:0]     x;
    logic [8:0]     n_ent;
    logic           bad;
    logic           ferr;
    logic           line_we;
    logic           pal_we;
    logic           res_v;
    logic [7:0]     res0;
    logic [7:0]     res1;
    logic [7:0]     res2;
    logic [1:0]     res_err;

    // The whole back pipeline advances unless a finished result is held.
    assign en    = !(r_ov && i_stall);
    assign o_pop = en && !i_empty;

    // Filter reversal for the transaction in stage one.
    always_comb begin
        bpp3   = (i_cfg.pixel_mode == MODE_RGB);
        b      = r1_cmd.first_row ? 8'd0 : (r_fwd ? r_fwd_d : (r_unw ? 8'd0 : r_rd));
        a      = 8'd0;
        c      = 8'd0;
        if (r1_cmd.has_left) begin
            a = bpp3 ? r_left[23:16] : r_left[7:0];
            if (!r1_cmd.first_row) begin
                c = bpp3 ? r_ul[23:16] : r_ul[7:0];
            end
        end
        sum_ab = {1'b0, a} + {1'b0, b};
        unique case (r_filter)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = sum_ab[8:1];
            FLT_PAETH: pred = paeth(a, b, c);
            default:   pred = 8'd0;
        endcase
        x       = r1_cmd.data + pred;
        n_ent   = (i_cfg.palette_entries > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH)
                                                             : i_cfg.palette_entries;
        bad     = ({1'b0, x} >= n_ent);
        ferr    = (r1_cmd.data > FLT_MAX);
        line_we = en && r1_v && (r1_cmd.kind == K_SAMPLE);
        pal_we  = en && r1_v && (r1_cmd.kind == K_PAL)
                  && ({1'b0, r1_cmd.pal_idx} < 9'(PALETTE_DEPTH));
    end

    // Line buffer: one write and one registered read a cycle while the pipeline
    // advances, with bypass of a write to the address being read.
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line[r1_cmd.col[AW-1:0]] <= x;
        end
        if (en) begin
            r_rd    <= r_line[i_head.col[AW-1:0]];
            r_unw   <= ({1'b0, i_head.col} >= r_line_lim);
            r_fwd   <= line_we && (r1_cmd.col[AW-1:0] == i_head.col[AW-1:0]);
            r_fwd_d <= x;
        end
    end

    // Rows are always written from column zero upwards, so the bytes written
    // since reset form a prefix; bytes beyond it read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_lim <= '0;
        end else if (line_we && ({1'b0, r1_cmd.col} >= r_line_lim)) begin
            r_line_lim <= {1'b0, r1_cmd.col} + LW'(1);
        end
    end

    // Palette store and its registered read.
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal[r1_cmd.pal_idx[PW-1:0]] <= r1_cmd.pal_rgb;
        end
        if (en) begin
            r_pal_rd <= r_pal[x[PW-1:0]];
        end
    end

    // Stage one and the per-row filter history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r_filter <= FLT_NONE;
            r_left   <= '0;
            r_ul     <= '0;
        end else if (en) begin
            r1_v <= !i_empty;
            if (r1_v && r1_cmd.kind == K_FILT) begin
                r_filter <= ferr ? FLT_NONE : r1_cmd.data[2:0];
                r_left   <= '0;
                r_ul     <= '0;
            end else if (r1_v && r1_cmd.kind == K_SAMPLE) begin
                r_left <= {r_left[15:0], x};
                r_ul   <= {r_ul[15:0], b};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd <= i_head;
        end
    end

    // Stage two registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v && (r1_cmd.kind != K_PAL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_kind      <= r1_cmd.kind;
            r2_x         <= x;
            r2_bad       <= bad;
            r2_pal       <= (i_cfg.pixel_mode == MODE_PAL);
            r2_ferr      <= ferr;
            r2_first_row <= r1_cmd.first_row;
            r2_rend      <= r1_cmd.row_end;
            r2_iend      <= r1_cmd.row_end && r1_cmd.image_end;
        end
    end

    // Result forming and grey tracking.
    always_comb begin
        n_gray  = r_gray;
        res_v   = 1'b0;
        res0    = 8'd0;
        res1    = 8'd0;
        res2    = 8'd0;
        res_err = ERR_OK;
        if (r2_v && r2_kind == K_FILT) begin
            if (r2_first_row) begin
                n_gray = 1'b1;
            end
            if (r2_ferr) begin
                res_v   = 1'b1;
                res_err = ERR_FILTER;
            end
        end else if (r2_v) begin
            res_v = 1'b1;
            if (!r2_pal) begin
                res0 = r2_x;
            end else if (r2_bad) begin
                res_err = ERR_PALETTE;
            end else begin
                res0 = r_pal_rd[23:16];
                res1 = r_pal_rd[15:8];
                res2 = r_pal_rd[7:0];
                if (!(res0 == res1 && res1 == res2)) begin
                    n_gray = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray <= 1'b1;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_gray <= n_gray;
            r_ov   <= res_v;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_byte0  <= res0;
            o_out_byte1  <= res1;
            o_out_byte2  <= res2;
            o_error_code <= res_err;
            o_row_end    <= res_v && r2_kind == K_SAMPLE && r2_rend;
            o_image_end  <= res_v && r2_kind == K_SAMPLE && r2_iend;
            o_all_gray   <= n_gray;
        end
    end

    assign o_valid = r_ov;

`ifndef ASSERT_OFF
    a_iend_has_rend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_image_end || o_row_end))
        else $error("image end without row end");
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_code != 2'd3))
        else $error("unused error code");
    a_ferr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code == ERR_FILTER) |-> (!o_row_end && o_out_byte0 == 8'd0))
        else $error("filter error result carries data");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: hdl/png_scanline_unfilter_top.sv
// Top level of the PNG scanline unfilter.
`default_nettype none
// Takes one inflated PNG byte per cycle unless stalled (filter type byte, then the row's
// filtered samples) and returns one result per sample byte and per invalid filter type
// byte, sustaining one transaction a cycle while the output is not stalled. A result
// passes through the queue, the registered line buffer read as the byte leaves the
// queue, the registered palette read and the output register. The input stalls only
// when the four-entry queue is full, which happens only after the output has been stalled.
module png_scanline_unfilter_top #(
    parameter int MAX_ROW_BYTES = 12288,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic           i_func,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic [7:0]     i_palette_index,
    input  wire logic [23:0]    i_palette_rgb,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [7:0]          o_out_byte0,
    output logic [7:0]          o_out_byte1,
    output logic [7:0]          o_out_byte2,
    output logic [1:0]          o_error_code,
    output logic                o_row_end,
    output logic                o_image_end,
    output logic                o_all_gray
);
    import pngu_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_cmd   cmd;
    t_cmd   head;
    t_cfg   cfg;

    assign o_stall = full;

    pngu_front #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_palette_index(i_palette_index),
        .i_palette_rgb  (i_palette_rgb),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (cmd),
        .o_cfg          (cfg)
    );

    pngu_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_head (head)
    );

    pngu_back #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES),
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_byte0 (o_out_byte0),
        .o_out_byte1 (o_out_byte1),
        .o_out_byte2 (o_out_byte2),
        .o_error_code(o_error_code),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end),
        .o_all_gray  (o_all_gray)
    );

endmodule
`default_nettype wire
